>>> rtl/itr_pkg.sv
// shared types, constants and helpers for the radix text converter
`default_nettype none

package itr_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W = 7;
    localparam int BASE_W = 6;

    localparam logic [BASE_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [BASE_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_LOAD,
        ST_POP,
        ST_TERM
    } itr_state_t;

    // one remainder digit handed from the divider to the control
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [DIGIT_W-1:0] value;
    } itr_digit_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_TEN)
            ch = CHAR_ZERO + {1'b0, d};
        else
            ch = CHAR_A + {1'b0, d} - {1'b0, DIGIT_TEN};
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/itr_if.sv
// valid/ready channel interfaces for input values and output characters
`default_nettype none

interface itr_in_if
    import itr_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VALUE_BITS-1:0] number;
    logic [BASE_W-1:0]           base;

    modport source (output valid, output number, output base, input ready);
    modport sink (input valid, input number, input base, output ready);
endinterface

interface itr_out_if
    import itr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
    logic              bad_base;

    modport source (output valid, output char_code, output last_char, output bad_base,
                    input ready);
    modport sink (input valid, input char_code, input last_char, input bad_base,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/itr_div.sv
// bit-serial restoring divider that peels off digits least significant first
`default_nettype none

module itr_div
    import itr_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [BASE_W-1:0]     radix,
    output itr_digit_t                 dig
);

    localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);

    logic                  run_reg, run_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [BASE_W-1:0]     radix_reg, radix_next;
    logic [BW-1:0]         bit_reg, bit_next;
    logic                  nz_reg, nz_next;

    logic [DIGIT_W:0]      trial;
    logic                  ge;
    logic [DIGIT_W:0]      diff;
    logic [DIGIT_W-1:0]    rem_step;

    always_comb
    begin
        trial = {rem_reg, q_reg[VALUE_BITS-1]};
        ge = trial >= {1'b0, radix_reg};
        diff = trial - {1'b0, radix_reg};
        rem_step = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

        run_next = run_reg;
        q_next = q_reg;
        rem_next = rem_reg;
        radix_next = radix_reg;
        bit_next = bit_reg;
        nz_next = nz_reg;
        dig = '0;

        if (start)
        begin
            run_next = 1'b1;
            q_next = dividend;
            rem_next = '0;
            radix_next = radix;
            bit_next = '0;
            nz_next = 1'b0;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[VALUE_BITS-2:0], ge};
            rem_next = rem_step;
            nz_next = nz_reg | ge;
            bit_next = bit_reg + 1'b1;
            if (bit_reg == BIT_LAST)
            begin
                // one digit done, quotient stays in place for the next pass
                dig.valid = 1'b1;
                dig.value = rem_step;
                dig.last = !(nz_reg | ge);
                rem_next = '0;
                bit_next = '0;
                nz_next = 1'b0;
                run_next = nz_reg | ge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= 1'b0;
        else
            run_reg <= run_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        radix_reg <= radix_next;
        bit_reg <= bit_next;
        nz_reg <= nz_next;
    end

endmodule

`default_nettype wire

>>> rtl/itr_stack.sv
// digit memory used as a stack to reverse the digit order
`default_nettype none

module itr_stack
    import itr_pkg::*;
#(
    parameter int DEPTH = VALUE_BITS_DEF,
    parameter int AW = $clog2(VALUE_BITS_DEF)
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [DIGIT_W-1:0] wr_data,
    input  wire logic [AW-1:0]      rd_addr,
    output logic [DIGIT_W-1:0]      rd_data
);

    logic [DIGIT_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/int_to_radix_text_top.sv
// top level: signed integer to ascii text in radix 2 to 36
// flow: the divider peels the digits off least significant first into the stack; then an
//   optional minus sign, the digits most significant first and a NUL terminator go out
// a new value is taken only once the terminator of the previous one is registered;
//   the bit-serial divider makes one quotient bit per cycle; bad radix gives the terminator only
// reset: rst_n asynchronous active low clears control state and output valid, not the memory
`default_nettype none

module int_to_radix_text_top
    import itr_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    itr_in_if.sink    in_ch,
    itr_out_if.source out_ch
);

    // at most VALUE_BITS digits since the radix is at least two
    localparam int AW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    itr_state_t state_reg, state_next;

    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              bad_reg, bad_next;

    // output word register
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              badf_reg, badf_next;

    logic                  in_fire;
    logic                  out_free;
    logic                  radix_bad;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] num_u;
    logic [VALUE_BITS-1:0] mag;
    logic                  div_start;
    itr_digit_t            dig;
    logic                  wr_en;
    logic [DIGIT_W-1:0]    rd_data;
    logic [CW-1:0]         rd_ptr;

    itr_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(mag),
        .radix   (in_ch.base),
        .dig     (dig)
    );

    itr_stack #(
        .DEPTH(VALUE_BITS),
        .AW   (AW)
    ) u_stack (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(cnt_reg[AW-1:0]),
        .wr_data(dig.value),
        .rd_addr(rd_ptr[AW-1:0]),
        .rd_data(rd_data)
    );

    always_comb
    begin
        num_u = in_ch.number;
        radix_bad = (in_ch.base < RADIX_MIN) || (in_ch.base > RADIX_MAX);
        // minus sign only in decimal, other radixes show the raw pattern
        neg_in = num_u[VALUE_BITS-1] && (in_ch.base == RADIX_DEC);
        mag = neg_in ? ({VALUE_BITS{1'b0}} - num_u) : num_u;

        out_free = !out_valid_reg || out_ch.ready;
        in_ch.ready = (state_reg == ST_IDLE);
        in_fire = in_ch.valid && in_ch.ready;

        state_next = state_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        bad_next = bad_reg;
        div_start = 1'b0;
        wr_en = 1'b0;

        out_valid_next = out_valid_reg && !out_ch.ready;
        char_next = char_reg;
        last_next = last_reg;
        badf_next = badf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next = '0;
                    neg_next = neg_in;
                    bad_next = radix_bad;
                    if (radix_bad)
                        state_next = ST_TERM;
                    else
                    begin
                        div_start = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (dig.valid)
                begin
                    wr_en = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (dig.last)
                        state_next = neg_reg ? ST_SIGN : ST_LOAD;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = CHAR_MINUS;
                    last_next = 1'b0;
                    badf_next = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // lets the memory read of the top digit settle
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = digit_char(rd_data);
                    last_next = 1'b0;
                    badf_next = 1'b0;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_ONE)
                        state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next = CHAR_NUL;
                    last_next = 1'b1;
                    badf_next = bad_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // read ahead so the registered data matches the top of stack next cycle
        rd_ptr = cnt_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
            neg_reg <= 1'b0;
            bad_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg <= cnt_next;
            neg_reg <= neg_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        badf_reg <= badf_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.char_code = char_reg;
    assign out_ch.last_char = last_reg;
    assign out_ch.bad_base = badf_reg;

endmodule

`default_nettype wire

>>> sim/int_to_radix_text_top_tb.sv
// self-checking testbench for the signed integer to radix text converter
`timescale 1ns / 100ps

module int_to_radix_text_top_tb
    import itr_pkg::*;
;

    localparam int VALUE_BITS = VALUE_BITS_DEF;
    // output stall used to back the block up while the sender keeps going
    localparam int HOLD_CYCLES = 400;
    // quiet time after the last character, to catch stray words
    localparam int DRAIN_CYCLES = 64;

    // one output word as the block should produce it
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
        logic              bad_base;
    } text_char_t;

    logic clk;
    logic rst_n;

    // characters still owed by the block, oldest first
    text_char_t pending_chars[$];
    int         error_count;

    // idling switches for the two sides of the block
    bit src_idle_on;
    bit sink_idle_on;
    // bumped by a test to ask the sink for one long stall
    int hold_requests;

    itr_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
    itr_out_if out_ch ();

    int_to_radix_text_top #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #10 clk = ~clk;

    // appends one owed character behind the others
    function automatic void owe_char(input text_char_t ch);
        pending_chars.insert(pending_chars.size(), ch);
    endfunction

    // works out the characters for one value and queues them up
    function automatic void predict_text(input logic [VALUE_BITS-1:0] pattern,
                                         input logic [BASE_W-1:0] radix);
        string              digit_set;
        logic [VALUE_BITS-1:0] magnitude;
        logic [DIGIT_W-1:0] digit_q[$];
        bit                 minus;
        text_char_t         ch;
        digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
        // rejected radix: just the terminator with the error flag
        if (radix < RADIX_MIN || radix > RADIX_MAX)
        begin
            ch = '{char_code: CHAR_NUL, last_char: 1'b1, bad_base: 1'b1};
            owe_char(ch);
            return;
        end
        // only radix ten shows a sign, any other radix shows the raw pattern
        minus = pattern[VALUE_BITS-1] && (radix == RADIX_DEC);
        magnitude = minus ? (~pattern + 1'b1) : pattern;
        // repeated division, remainders collected most significant first
        do
        begin
            digit_q.push_front(DIGIT_W'(magnitude % radix));
            magnitude = magnitude / radix;
        end
        while (magnitude != '0);
        if (minus)
        begin
            ch = '{char_code: CHAR_MINUS, last_char: 1'b0, bad_base: 1'b0};
            owe_char(ch);
        end
        foreach (digit_q[i])
        begin
            ch = '{char_code: CHAR_W'(digit_set[digit_q[i]]), last_char: 1'b0,
                   bad_base: 1'b0};
            owe_char(ch);
        end
        ch = '{char_code: CHAR_NUL, last_char: 1'b1, bad_base: 1'b0};
        owe_char(ch);
    endfunction

    // offers one value to the block and returns at the falling edge after the
    // handshake, with valid still high so the next word can follow at once
    task automatic send_number(input logic signed [VALUE_BITS-1:0] value,
                               input logic [BASE_W-1:0] radix);
        while (src_idle_on && $urandom_range(99) < 15)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.number <= value;
        in_ch.base   <= radix;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_text(value, radix);
        @(negedge clk);
    endtask

    // sender stops until every owed character has come out
    task automatic wait_for_text;
        in_ch.valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [BASE_W-1:0] pick_radix;
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return ($urandom_range(1)) ? BASE_W'($urandom_range(1)) :
                                         BASE_W'($urandom_range(37, 63));
        else if (sel < 35)
            return RADIX_DEC;
        else if (sel < 50)
            return BASE_W'(16);
        else if (sel < 58)
            return RADIX_MIN;
        else if (sel < 65)
            return RADIX_MAX;
        else
            return BASE_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] pick_number;
        case ($urandom_range(5))
            0: return VALUE_BITS'($urandom);
            1: return VALUE_BITS'($urandom_range(99));
            2: return -$signed(VALUE_BITS'($urandom_range(1, 1000)));
            3: return VALUE_BITS'($urandom_range(65535));
            4: return -$signed(VALUE_BITS'($urandom));
            default:
                case ($urandom_range(3))
                    0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
                    1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
                    2: return '1;
                    default: return '0;
                endcase
        endcase
    endfunction

    // radix edges: out of range below and above, both ends of the valid range
    task automatic test_radix_range;
        send_number(32'sd1234, BASE_W'(0));
        send_number(32'sd1234, BASE_W'(1));
        send_number(-32'sd5, BASE_W'(37));
        send_number('1, '1);
        send_number('1, RADIX_MIN);           // all ones in binary, longest string
        send_number(32'sd5, RADIX_MIN);
        send_number('1, RADIX_MAX);
        send_number(32'sd35, RADIX_MAX);      // single 'z'
        send_number(32'sd36, RADIX_MAX);
        send_number(32'sd10, BASE_W'(11));    // single 'a'
    endtask

    // zero, sign handling and the most negative value
    task automatic test_special_values;
        send_number('0, RADIX_DEC);
        send_number('0, RADIX_MIN);
        send_number('0, RADIX_MAX);
        send_number({1'b1, {(VALUE_BITS-1){1'b0}}}, RADIX_DEC);
        send_number({1'b0, {(VALUE_BITS-1){1'b1}}}, RADIX_DEC);
        send_number(-32'sd1, RADIX_DEC);
        send_number(-32'sd1, BASE_W'(16));
        send_number(-32'sd1, BASE_W'(8));
        send_number({1'b1, {(VALUE_BITS-1){1'b0}}}, BASE_W'(16));
        send_number(32'sd9, RADIX_DEC);
        send_number(32'sh0123abcd, BASE_W'(16));
        send_number(32'sh76543210, BASE_W'(3));
        wait_for_text();
    endtask

    // no idling on either side, words go back to back
    task automatic test_back_to_back;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (20)
            send_number(pick_number(), pick_radix());
        wait_for_text();
    endtask

    // sink stalls for a long time while values keep coming, so the block
    // backs up and has to stall its input
    task automatic test_output_backpressure;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_requests++;
        repeat (6)
            send_number(pick_number(), BASE_W'(16));
        wait_for_text();
    endtask

    task automatic test_random_values;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        repeat (62)
            send_number(pick_number(), pick_radix());
    endtask

    // sink side: random stalls, plus a long stall on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= !(sink_idle_on && $urandom_range(99) < 15);
            end
        end
    end

    // every accepted character is held against the oldest owed one
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected word: char_code %0h last_char %0b bad_base %0b",
                       out_ch.char_code, out_ch.last_char, out_ch.bad_base);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_ch.char_code !== want.char_code)
                begin
                    $error("char_code: expected %0h, got %0h",
                           want.char_code, out_ch.char_code);
                    error_count++;
                end
                if (out_ch.last_char !== want.last_char)
                begin
                    $error("last_char: expected %0b, got %0b",
                           want.last_char, out_ch.last_char);
                    error_count++;
                end
                if (out_ch.bad_base !== want.bad_base)
                begin
                    $error("bad_base: expected %0b, got %0b",
                           want.bad_base, out_ch.bad_base);
                    error_count++;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        error_count   = 0;
        hold_requests = 0;
        src_idle_on   = 1'b1;
        sink_idle_on  = 1'b1;
        in_ch.valid   = 1'b0;
        in_ch.number  = '0;
        in_ch.base    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_radix_range();
        test_special_values();
        test_back_to_back();
        test_output_backpressure();
        test_random_values();

        // let everything owed come out, then watch for stray words
        wait_for_text();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
